### src/berd_pkg.sv
// Package for the border entrance run detector.
// Holds widths, limits, reset values and the result entry type.
// No dependencies.
package berd_pkg;

    localparam int SEGMENT_MAX = 256;
    localparam int POS_W       = 8;
    localparam int RUN_W       = 9;
    localparam int CFG_W       = 9;

    localparam logic [POS_W-1:0] POS_CAP   =
        POS_W'((SEGMENT_MAX - 1) < 255 ? (SEGMENT_MAX - 1) : 255);
    localparam logic [RUN_W-1:0] RUN_CAP   = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(6);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0] offset;
        logic             last;
    } result_t;

endpackage

### src/border_entrance_run_detector_top.sv
// Border entrance run detector: scans border cell pairs and emits entrance offsets.
// Accepted beats are registered, then their results go to the 4-entry result queue;
// one input beat per cycle while it holds at most 2 beats; a run yields 0, 1 or 2.
// With m_tready high it drains one result beat per cycle, setting the double-result rate.
// Reset (aresetn low, synchronous): run length and position cleared, queue emptied,
// threshold register back to 6.
module border_entrance_run_detector_top
    import berd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,   // two_entrance_min_len
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [0] near_open, [1] far_open, [7:2] zero
    input  logic       s_tlast,       // segment_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] entrance_offset
    output logic       m_tlast        // last_of_run
);

    logic [CFG_W-1:0] thr_reg;
    logic             in_valid_reg;
    logic             near_reg, far_reg, end_reg;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic             advance, pop, is_open, emit, two;
    logic [RUN_W-1:0] run_inc, emit_len, thr;
    logic [POS_W-1:0] last_pos, first_off, mid_off;
    logic [1:0]       push_n;
    result_t          res0, res1;

    assign advance  = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || advance;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        is_open  = near_reg && far_reg;
        run_inc  = (run_reg == RUN_CAP) ? run_reg : run_reg + RUN_W'(1);
        emit_len = is_open ? run_inc : run_reg;
        emit     = is_open ? end_reg : 1'b1;
        last_pos = is_open ? pos_reg
                           : ((pos_reg == '0) ? '0 : pos_reg - POS_W'(1));
        thr      = (thr_reg == '0) ? RUN_W'(1) : RUN_W'(thr_reg);
        two      = emit_len >= thr;

        if (RUN_W'(last_pos) > (emit_len - RUN_W'(1))) begin
            first_off = POS_W'(RUN_W'(last_pos) - (emit_len - RUN_W'(1)));
        end else begin
            first_off = '0;
        end
        if (RUN_W'(last_pos) > (emit_len >> 1)) begin
            mid_off = POS_W'(RUN_W'(last_pos) - (emit_len >> 1));
        end else begin
            mid_off = '0;
        end

        if (!advance || !emit || emit_len == '0) begin
            push_n = 2'd0;
        end else if (two) begin
            push_n = 2'd2;
        end else begin
            push_n = 2'd1;
        end

        res0.offset = two ? last_pos : mid_off;
        res0.last   = !two;
        res1.offset = first_off;
        res1.last   = 1'b1;

        if (end_reg) begin
            run_next = '0;
        end else if (is_open) begin
            run_next = run_inc;
        end else begin
            run_next = '0;
        end

        if (end_reg) begin
            pos_next = '0;
        end else if (pos_reg < POS_CAP) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= CFG_RESET;
            in_valid_reg <= 1'b0;
            run_reg      <= '0;
            pos_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                run_reg <= run_next;
                pos_reg <= pos_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            near_reg <= s_tdata[0];
            far_reg  <= s_tdata[1];
            end_reg  <= s_tlast;
        end
        if (push_n != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = fifo_reg[rd_ptr_reg].offset;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

### src/berd_checker.sv
// Port-level checker for the border entrance run detector.
// Depends on border_entrance_run_detector_top; bound to it below.
module berd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_stall_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled without pending result beats");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

endmodule

bind border_entrance_run_detector_top berd_checker u_berd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
